>>> hdl/dcg_pkg.sv
// dcg_pkg: shared constants for the dual cosine generator
// holds register codes, field widths and the quarter-sine polynomial coefficients
// no dependencies
package dcg_pkg;

	// field widths
	localparam int PERIOD_W = 16;
	localparam int OFFSET_W = 16;
	localparam int PEAK_W   = 15;
	localparam int SAMPLE_W = 16;
	localparam int CFG_IDX_W = 3;

	// register codes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_NUM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_DEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEFT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_RIGHT = 3'd4;

	// sin(pi/2 x) ~ x*(A - x^2*(B - x^2*C)), Q2.30
	localparam logic [30:0] SIN_A   = 31'd1686629713;
	localparam logic [29:0] SIN_B   = 30'd688904866;
	localparam logic [26:0] SIN_C   = 27'd76016977;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	localparam logic [PEAK_W-1:0] PEAK_RESET = 15'h7FFF;

endpackage

>>> hdl/dcg_divider.sv
// dcg_divider: pipelined restoring divider, one quotient bit per stage
// gives quotient and remainder of an NW-bit value by a 16-bit divisor
// depends on nothing but its parameters
module dcg_divider #(
	parameter int NW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic          in_tag,
	input  logic [15:0]   divisor,
	output logic          out_valid,
	output logic [NW-1:0] out_quot,
	output logic [15:0]   out_rem,
	output logic          out_tag
);

	logic [15:0]   rem_s   [1:NW];
	logic [NW-1:0] num_s   [1:NW];
	logic [NW-1:0] quot_s  [1:NW];
	logic          tag_s   [1:NW];
	logic          valid_s [1:NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [15:0]   rem_in;
		logic [NW-1:0] num_in;
		logic [NW-1:0] quot_in;
		logic          tag_in;
		logic          valid_in;
		logic [16:0]   trial;
		logic [16:0]   diff;
		logic          ge;
		logic [15:0]   rem_next;
		logic [NW-1:0] quot_next;

		if (i == 0) begin : g_first
			assign rem_in   = '0;
			assign num_in   = in_num;
			assign quot_in  = '0;
			assign tag_in   = in_tag;
			assign valid_in = in_valid;
		end else begin : g_next
			assign rem_in   = rem_s[i];
			assign num_in   = num_s[i];
			assign quot_in  = quot_s[i];
			assign tag_in   = tag_s[i];
			assign valid_in = valid_s[i];
		end

		// shift in the next numerator bit and try the subtract
		always_comb begin
			trial     = {rem_in, num_in[NW-1-i]};
			diff      = trial - {1'b0, divisor};
			ge        = (trial >= {1'b0, divisor});
			rem_next  = ge ? diff[15:0] : trial[15:0];
			quot_next = quot_in;
			quot_next[NW-1-i] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= rem_next;
			num_s[i+1]  <= num_in;
			quot_s[i+1] <= quot_next;
			tag_s[i+1]  <= tag_in;
		end
	end

	assign out_valid = valid_s[NW];
	assign out_quot  = quot_s[NW];
	assign out_rem   = rem_s[NW];
	assign out_tag   = tag_s[NW];

endmodule

>>> hdl/dcg_cosine.sv
// dcg_cosine: seven-stage scaled cosine of a Q0.32 turn angle
// folds the quadrant, evaluates the quarter-sine polynomial, scales by the peak
// depends on dcg_pkg
module dcg_cosine
	import dcg_pkg::*;
#(
	parameter int PHASE_BITS = 16,
	parameter int AMP_BITS   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [31:0]         angle,
	input  logic [PEAK_W-1:0]   peak,
	input  logic                in_tag,
	output logic                out_valid,
	output logic [SAMPLE_W-1:0] sample,
	output logic                out_tag
);

	logic [7:1] valid_s;
	logic       tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	logic [1:0] quad_s1, quad_s2, quad_s3, quad_s4, quad_s5, quad_s6;

	logic [30:0] x_s1, x_s2, x_s3, x_s4;
	logic [30:0] x2_s2, x2_s3;
	logic [29:0] u_s3;
	logic [30:0] v_s4;
	logic [30:0] y_s5;
	logic [15:0] mag_s6;
	logic [SAMPLE_W-1:0] out_s7;

	logic [31:0] sa;
	logic [29:0] f;
	logic [61:0] sq;
	logic [57:0] p1;
	logic [60:0] p2;
	logic [61:0] p3;
	logic [31:0] y0;
	logic [31:0] csum;
	logic [AMP_BITS-1:0] c;
	logic [AMP_BITS+15:0] msum;

	always_comb begin
		// keep the top phase bits, add a quarter turn so sin gives cos
		sa = {angle[31:32-PHASE_BITS], {(32-PHASE_BITS){1'b0}}} + 32'h4000_0000;
		f  = sa[29:0];
		sq = 62'(x_s1) * 62'(x_s1);
		p1 = 58'(x2_s2) * 58'(SIN_C);
		p2 = 61'(x2_s3) * 61'(u_s3);
		p3 = 62'(x_s4) * 62'(v_s4);
		y0 = p3[61:30];
		csum = 32'(y_s5) + (32'd1 << (30 - AMP_BITS));
		c    = csum[30:31-AMP_BITS];
		msum = (AMP_BITS+16)'(peak) * (AMP_BITS+16)'(c) + ((AMP_BITS+16)'(1) << (AMP_BITS - 2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[6:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		// fold to [0, 1] within the quadrant
		quad_s1 <= sa[31:30];
		x_s1    <= sa[30] ? (ONE_Q30 - {1'b0, f}) : {1'b0, f};
		tag_s1  <= in_tag;
		// x^2
		x2_s2   <= sq[60:30];
		x_s2    <= x_s1;
		quad_s2 <= quad_s1;
		tag_s2  <= tag_s1;
		// B - x^2*C
		u_s3    <= SIN_B - p1[57:30];
		x2_s3   <= x2_s2;
		x_s3    <= x_s2;
		quad_s3 <= quad_s2;
		tag_s3  <= tag_s2;
		// A - x^2*u
		v_s4    <= SIN_A - p2[60:30];
		x_s4    <= x_s3;
		quad_s4 <= quad_s3;
		tag_s4  <= tag_s3;
		// x*v clamped to one
		y_s5    <= (y0 > 32'(ONE_Q30)) ? ONE_Q30 : y0[30:0];
		quad_s5 <= quad_s4;
		tag_s5  <= tag_s4;
		// round and scale by the peak
		mag_s6  <= msum[AMP_BITS+14:AMP_BITS-1];
		quad_s6 <= quad_s5;
		tag_s6  <= tag_s5;
		// quadrant sign last
		out_s7  <= quad_s6[1] ? (16'd0 - mag_s6) : mag_s6;
		tag_s7  <= tag_s6;
	end

	assign out_valid = valid_s[7];
	assign sample    = out_s7;
	assign out_tag   = tag_s7;

endmodule

>>> hdl/dual_cosine_generator.sv
// dual_cosine_generator: top level of the quadrature-pair oscillator
// instantiates dcg_divider (twice) and dcg_cosine (twice); depends on dcg_pkg
//
// usage
//  - a sample index is taken on any clock edge with start high and busy low;
//    busy stays low, so a new index can be given every cycle
//  - each index gives one transaction on the result side: done is high for
//    exactly one cycle with left_sample and right_sample valid in that cycle
//  - the pipeline holds the bit-per-stage modulo of index*den and the
//    bit-per-stage phase division, plus seven stages of cosine evaluation
//  - throughput is one sample per clock; results come out in order
//  - the receiver cannot stall: results are shown once and not held
//  - registers are written on the cfg channel (cfg_ready is always high);
//    write them only while no sample is in flight
//  - reset clears the pipeline valid bits and loads the register defaults:
//    both periods zero (alternating mode), offset zero, full-scale peaks
module dual_cosine_generator
	import dcg_pkg::*;
#(
	parameter int PHASE_BITS = 16,
	parameter int AMP_BITS   = 16,
	parameter int INDEX_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// sample command
	input  logic                 start,
	output logic                 busy,
	input  logic [31:0]          sample_index,
	// result transaction
	output logic                 done,
	output logic [SAMPLE_W-1:0]  left_sample,
	output logic [SAMPLE_W-1:0]  right_sample,
	// register write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	localparam int PW = INDEX_BITS + PERIOD_W;     // index*den width
	localparam int DW = PERIOD_W + PHASE_BITS + 1; // phase numerator width

	// configuration registers
	logic [PERIOD_W-1:0] period_num_q;
	logic [PERIOD_W-1:0] period_den_q;
	logic [OFFSET_W-1:0] phase_ofs_q;
	logic [PEAK_W-1:0]   peak_left_q;
	logic [PEAK_W-1:0]   peak_right_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_num_q <= '0;
			period_den_q <= '0;
			phase_ofs_q  <= '0;
			peak_left_q  <= PEAK_RESET;
			peak_right_q <= PEAK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PERIOD_NUM: period_num_q <= cfg_data;
				REG_PERIOD_DEN: period_den_q <= cfg_data;
				REG_PHASE_OFS:  phase_ofs_q  <= cfg_data;
				REG_PEAK_LEFT:  peak_left_q  <= cfg_data[PEAK_W-1:0];
				REG_PEAK_RIGHT: peak_right_q <= cfg_data[PEAK_W-1:0];
				default: ; // unknown index, write dropped
			endcase
		end
	end

	// stage 1: capture the index, upper bits dropped
	logic                  valid_s1;
	logic [INDEX_BITS-1:0] idx_s1;
	// stage 2: index times denominator
	logic                  valid_s2;
	logic [PW-1:0]         prod_s2;
	logic                  lsb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= INDEX_BITS'(sample_index);
		prod_s2 <= PW'(idx_s1) * PW'(period_den_q);
		lsb_s2  <= idx_s1[0];
	end

	// (index*den) mod num, one bit per stage
	logic          mod_valid;
	logic [15:0]   mod_rem;
	logic          mod_lsb;

	dcg_divider #(
		.NW (PW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_num    (prod_s2),
		.in_tag    (lsb_s2),
		.divisor   (period_num_q),
		.out_valid (mod_valid),
		.out_quot  (),
		.out_rem   (mod_rem),
		.out_tag   (mod_lsb)
	);

	// stage 3: r * 2^PHASE_BITS + num/2, rounds the phase quotient
	logic          valid_s3;
	logic [DW-1:0] pnum_s3;
	logic          lsb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= mod_valid;
		end
	end

	always_ff @(posedge clk) begin
		pnum_s3 <= (DW'(mod_rem) << PHASE_BITS) + DW'(period_num_q >> 1);
		lsb_s3  <= mod_lsb;
	end

	// phase = round(r * 2^PHASE_BITS / num)
	logic          div_valid;
	logic [DW-1:0] div_quot;
	logic          div_lsb;

	dcg_divider #(
		.NW (DW)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_num    (pnum_s3),
		.in_tag    (lsb_s3),
		.divisor   (period_num_q),
		.out_valid (div_valid),
		.out_quot  (div_quot),
		.out_rem   (),
		.out_tag   (div_lsb)
	);

	// stage 4: channel angles, Q0.32 turns, offset split half each way
	logic        valid_s4;
	logic [31:0] angle_l_s4;
	logic [31:0] angle_r_s4;
	logic        lsb_s4;
	logic [31:0] base;
	logic [31:0] half;

	always_comb begin
		base = {div_quot[PHASE_BITS-1:0], {(32-PHASE_BITS){1'b0}}};
		half = {phase_ofs_q[15], phase_ofs_q, 15'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		angle_l_s4 <= base - half;
		angle_r_s4 <= base + half;
		lsb_s4     <= div_lsb;
	end

	// cosine evaluation, both channels in lock step
	logic                cos_valid;
	logic [SAMPLE_W-1:0] cos_left;
	logic [SAMPLE_W-1:0] cos_right;
	logic                cos_lsb;

	dcg_cosine #(
		.PHASE_BITS (PHASE_BITS),
		.AMP_BITS   (AMP_BITS)
	) u_cos_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.angle     (angle_l_s4),
		.peak      (peak_left_q),
		.in_tag    (lsb_s4),
		.out_valid (cos_valid),
		.sample    (cos_left),
		.out_tag   (cos_lsb)
	);

	dcg_cosine #(
		.PHASE_BITS (PHASE_BITS),
		.AMP_BITS   (AMP_BITS)
	) u_cos_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.angle     (angle_r_s4),
		.peak      (peak_right_q),
		.in_tag    (lsb_s4),
		.out_valid (),
		.sample    (cos_right),
		.out_tag   ()
	);

	// output register: alternating mode overrides the cosine when a period is zero
	logic                alt_mode;
	logic                done_q;
	logic [SAMPLE_W-1:0] left_q;
	logic [SAMPLE_W-1:0] right_q;

	assign alt_mode = (period_num_q == '0) || (period_den_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cos_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (alt_mode) begin
			// left on odd indices, right on even ones
			left_q  <= cos_lsb ? {1'b0, peak_left_q} : '0;
			right_q <= cos_lsb ? '0 : {1'b0, peak_right_q};
		end else begin
			left_q  <= cos_left;
			right_q <= cos_right;
		end
	end

	assign done         = done_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;

endmodule

>>> sim/dcg_checker.sv
// dcg_checker: predicts and checks the left/right samples of the dual cosine generator
// watches the command, result and register channels; depends on dcg_pkg
`timescale 1ns / 100ps
module dcg_checker
	import dcg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [31:0]          sample_index,
	input  logic                 done,
	input  logic [SAMPLE_W-1:0]  left_sample,
	input  logic [SAMPLE_W-1:0]  right_sample,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output int                   fail_count,
	output int                   pending
);
	typedef struct packed {
		logic [15:0] left;
		logic [15:0] right;
	} pair_t;

	pair_t sample_q[$];
	logic [15:0] num_r, den_r, ofs_r;
	logic [14:0] pkl_r, pkr_r;

	function automatic logic [63:0] sine_quarter(logic [63:0] x);
		logic [63:0] x2, u, v, y;
		x2 = (x * x) >> 30;
		u = 64'd688904866 - ((x2 * 64'd76016977) >> 30);
		v = 64'd1686629713 - ((x2 * u) >> 30);
		y = (x * v) >> 30;
		if (y > 64'h4000_0000) y = 64'h4000_0000;
		return y;
	endfunction

	function automatic logic [15:0] peak_cos(logic [31:0] angle, logic [14:0] peak);
		logic [31:0] s;
		logic [1:0] quad;
		logic [63:0] f, x, c, mag;
		s = {angle[31:16], 16'h0} + 32'h4000_0000;
		quad = s[31:30];
		f = {34'd0, s[29:0]};
		x = quad[0] ? (64'h4000_0000 - f) : f;
		c = (sine_quarter(x) + 64'd16384) >> 15;
		mag = ({49'd0, peak} * c + 64'd16384) >> 15;
		if (quad[1]) return 16'(17'h10000 - mag[16:0]);
		return mag[15:0];
	endfunction

	function automatic pair_t predict_pair(logic [31:0] idx);
		pair_t p;
		logic [63:0] r, ph;
		logic [31:0] base, half;
		if (num_r != 0 && den_r != 0) begin
			r = ({32'd0, idx} * den_r) % num_r;
			ph = (((r << 16) + (num_r >> 1)) / num_r) & 64'hFFFF;
			base = {ph[15:0], 16'h0};
			half = {{16{ofs_r[15]}}, ofs_r} << 15;
			p.left = peak_cos(base - half, pkl_r);
			p.right = peak_cos(base + half, pkr_r);
		end else begin
			p.left = idx[0] ? {1'b0, pkl_r} : 16'd0;
			p.right = idx[0] ? 16'd0 : {1'b0, pkr_r};
		end
		return p;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("%0t: %s got %0d expected %0d", $realtime, what, $signed(got), $signed(want));
		fail_count++;
	endtask

	assign pending = sample_q.size();

	always @(posedge clk or negedge arst_n) begin
		pair_t w;
		if (!arst_n) begin
			num_r <= '0; den_r <= '0; ofs_r <= '0;
			pkl_r <= PEAK_RESET; pkr_r <= PEAK_RESET;
			sample_q.delete();
			fail_count = 0;
		end else begin
			// results first so a same-edge command sees the queue as it was
			if (done) begin
				if (sample_q.size() == 0) begin
					$display("%0t: result with nothing expected", $realtime);
					fail_count++;
				end else begin
					w = sample_q.pop_front();
					if (left_sample !== w.left) report_mismatch("left", left_sample, w.left);
					if (right_sample !== w.right)
						report_mismatch("right", right_sample, w.right);
				end
			end
			if (start && !busy) sample_q.push_back(predict_pair(sample_index));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PERIOD_NUM: num_r <= cfg_data;
					REG_PERIOD_DEN: den_r <= cfg_data;
					REG_PHASE_OFS: ofs_r <= cfg_data;
					REG_PEAK_LEFT: pkl_r <= cfg_data[14:0];
					REG_PEAK_RIGHT: pkr_r <= cfg_data[14:0];
					default: ;
				endcase
			end
		end
	end
endmodule

>>> sim/tb.sv
// tb: stimulus and verdict for the dual cosine generator
// drives sample commands and register writes; depends on dcg_pkg, dcg_checker and dual_cosine_generator
`timescale 1ns / 100ps
module tb;
	import dcg_pkg::*;

	localparam int LATENCY = 93;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [31:0] sample_index = '0;
	logic done;
	logic [SAMPLE_W-1:0] left_sample, right_sample;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int fail_count, pending;
	int idle_cycles = 0;

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	dual_cosine_generator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample_index(sample_index), .done(done), .left_sample(left_sample),
		.right_sample(right_sample), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	dcg_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample_index(sample_index), .done(done), .left_sample(left_sample),
		.right_sample(right_sample), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// one register write transaction, with cfg_valid low again before the task returns
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drain outstanding samples, then let the pipeline settle
	task automatic wait_idle();
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// one sample command transaction; start stays high across back-to-back calls
	task automatic send_index(logic [31:0] idx);
		start <= 1'b1;
		sample_index <= idx;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic stop_sending();
		start <= 1'b0;
		sample_index <= $urandom;
	endtask

	task automatic set_all(logic [15:0] n, logic [15:0] d, logic [15:0] o,
			logic [15:0] pl, logic [15:0] pr);
		write_reg(REG_PERIOD_NUM, n);
		write_reg(REG_PERIOD_DEN, d);
		write_reg(REG_PHASE_OFS, o);
		write_reg(REG_PEAK_LEFT, pl);
		write_reg(REG_PEAK_RIGHT, pr);
	endtask

	// bursts of random length with random gaps, some long unbroken stretches
	task automatic random_phase(int count, bit small_idx);
		int burst, gap;
		logic [31:0] idx;
		while (count > 0) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && count > 0; k++) begin
				idx = small_idx ? 32'($urandom_range(0, 300)) : $urandom;
				send_index(idx);
				count--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				stop_sending();
				repeat (gap) @(posedge clk);
			end
		end
		stop_sending();
	endtask

	initial begin
		logic [15:0] n, d;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults give alternating mode
		send_index(32'd0);
		send_index(32'd1);
		send_index(32'hFFFF_FFFF);
		send_index(32'hFFFF_FFFE);
		stop_sending();
		wait_idle();

		// peak zero, offset extremes, period extremes, out-of-range register index
		set_all(16'hFFFF, 16'd1, 16'h8000, 16'h0000, 16'hFFFF);
		write_reg(3'd5, 16'h1234);
		write_reg(3'd7, 16'hFFFF);
		send_index(32'd0);
		send_index(32'd1);
		send_index(32'hFFFF_FFFF);
		send_index(32'h8000_0000);
		stop_sending();
		wait_idle();
		set_all(16'd4, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h0000);
		for (int i = 0; i < 6; i++) send_index(32'(i));
		send_index(32'hFFFF_FFFF);
		stop_sending();
		wait_idle();
		// one period register zero, the other not
		set_all(16'd0, 16'd5, 16'h4000, 16'h1234, 16'h7FFF);
		send_index(32'd2);
		send_index(32'd3);
		stop_sending();
		wait_idle();
		set_all(16'd1, 16'd0, 16'h0000, 16'h7FFF, 16'h4321);
		send_index(32'd7);
		send_index(32'd8);
		stop_sending();
		wait_idle();

		// random phases across many settings
		for (int ph = 0; ph < 11; ph++) begin
			n = (ph % 4 == 0) ? 16'($urandom_range(1, 64)) : 16'($urandom);
			d = (ph == 3) ? 16'd0 : 16'($urandom);
			if (ph == 5) n = 16'hFFFF;
			set_all(n, d, 16'($urandom), 16'($urandom), 16'($urandom));
			random_phase(100, ph % 3 == 1);
			// sender holds off until every result is back
			wait_idle();
		end

		wait_idle();
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

>>> dual_cosine_generator.f
hdl/dcg_pkg.sv
hdl/dcg_divider.sv
hdl/dcg_cosine.sv
hdl/dual_cosine_generator.sv
sim/dcg_checker.sv
sim/tb.sv
